// ===== design/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the tick timer bank
// Holds the command codes, the timer numbering, the prescaler constants and
// the structs that travel between the register block, the core and the top.
// ----------------------------------------------------------------------------
package ttb_pkg;

    // Prescaler lengths in ticks.
    localparam int TICKS_PER_SECOND = 100;
    localparam int TICKS_PER_MINUTE = 6000;
    localparam int SEC_W = $clog2(TICKS_PER_SECOND);
    localparam int MIN_W = $clog2(TICKS_PER_MINUTE);
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(TICKS_PER_SECOND - 1);
    localparam logic [MIN_W-1:0] MIN_LAST = MIN_W'(TICKS_PER_MINUTE - 1);

    // Timer bank.
    localparam int NUM_TIMERS = 12;
    localparam int TMR_W = 16;
    localparam logic [TMR_W-1:0] TMR_MAX = 16'hFFFF;
    localparam logic [TMR_W-1:0] WAKE_LIMIT = 16'd255;

    localparam logic [3:0] T_INTERVAL = 4'd0;
    localparam logic [3:0] T_UPTIME = 4'd1;
    localparam logic [3:0] T_LOAD_ON = 4'd2;
    localparam logic [3:0] T_EVENING = 4'd5;
    localparam logic [3:0] T_GREEN = 4'd8;
    localparam logic [3:0] T_RED = 4'd9;
    localparam logic [3:0] T_WAKE = 4'd10;
    localparam logic [3:0] T_SHUTDOWN = 4'd11;
    localparam logic [3:0] T_COUNT = 4'd12;

    // Status flag bits.
    localparam int FLAG_TEL = 0;
    localparam int FLAG_ADC = 1;
    localparam int FLAG_RST = 2;

    // Configuration register indexes (address bit 2).
    localparam logic REG_TEL_INTERVAL = 1'b0;
    localparam logic REG_ADC_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_READ   = 3'd2,
        CMD_ENABLE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [15:0] telemetry_interval_seconds;
        logic [15:0] adc_sample_period_ticks;
    } cfg_t;

    // Result word, lowest field last so that it packs into tdata directly.
    typedef struct packed {
        logic        radio_sleep_request;
        logic        red_led_on;
        logic        green_led_on;
        logic        adc_due;
        logic        telemetry_due;
        logic [15:0] read_value;
    } res_t;

endpackage

// ===== design/ttb_regs.sv =====
// ----------------------------------------------------------------------------
// ttb_regs: configuration registers
// APB-style port holding the telemetry interval and the ADC sample period.
// ----------------------------------------------------------------------------
module ttb_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ttb_pkg::cfg_t cfg
);

    logic        wr_en;
    logic [15:0] tel_interval_reg;
    logic [15:0] adc_period_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tel_interval_reg <= '0;
            adc_period_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                ttb_pkg::REG_TEL_INTERVAL: tel_interval_reg <= pwdata[15:0];
                ttb_pkg::REG_ADC_PERIOD:   adc_period_reg   <= pwdata[15:0];
                default:                   tel_interval_reg <= tel_interval_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ttb_pkg::REG_TEL_INTERVAL: prdata = {16'd0, tel_interval_reg};
            ttb_pkg::REG_ADC_PERIOD:   prdata = {16'd0, adc_period_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.telemetry_interval_seconds = tel_interval_reg;
    assign cfg.adc_sample_period_ticks    = adc_period_reg;

endmodule

// ===== design/ttb_core.sv =====
// ----------------------------------------------------------------------------
// ttb_core: timer state and per-command update
// Holds the twelve timers, prescalers, counters and flags, and works out the
// next state and the result word of one command in a single pass.
// ----------------------------------------------------------------------------
module ttb_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [2:0]    command,
    input  logic [3:0]    timer_index,
    input  logic [15:0]   write_value,
    input  ttb_pkg::cfg_t cfg,
    output ttb_pkg::res_t res
);

    logic [ttb_pkg::TMR_W-1:0] tmr_reg  [ttb_pkg::NUM_TIMERS];
    logic [ttb_pkg::TMR_W-1:0] tmr_next [ttb_pkg::NUM_TIMERS];
    logic [ttb_pkg::SEC_W-1:0] sec_pre_reg, sec_pre_next;
    logic [ttb_pkg::MIN_W-1:0] min_pre_reg, min_pre_next;
    logic [15:0]               tel_cnt_reg, tel_cnt_next;
    logic [15:0]               adc_cnt_reg, adc_cnt_next;
    logic [2:0]                enables_reg, enables_next;
    logic [2:0]                flags_reg, flags_next;
    logic [1:0]                leds_reg, leds_next;

    logic        sec_tick;
    logic        min_tick;
    logic [15:0] tel_sum;
    logic [15:0] adc_sum;
    logic        idx_ok;
    logic        sleep_req;

    assign sec_tick = (sec_pre_reg == ttb_pkg::SEC_LAST);
    assign min_tick = (min_pre_reg == ttb_pkg::MIN_LAST);
    assign tel_sum  = tel_cnt_reg + 16'd1;
    // A pending restart zeroes the count before this tick adds one.
    assign adc_sum  = (flags_reg[ttb_pkg::FLAG_RST] ? 16'd0 : adc_cnt_reg) + 16'd1;
    assign idx_ok   = (timer_index < ttb_pkg::T_COUNT);

    always_comb
    begin
        tmr_next     = tmr_reg;
        sec_pre_next = sec_pre_reg;
        min_pre_next = min_pre_reg;
        tel_cnt_next = tel_cnt_reg;
        adc_cnt_next = adc_cnt_reg;
        enables_next = enables_reg;
        flags_next   = flags_reg;
        leds_next    = leds_reg;
        sleep_req    = 1'b0;
        res.read_value = '0;

        case (command)
            ttb_pkg::CMD_TICK:
            begin
                if (tmr_reg[ttb_pkg::T_INTERVAL] != ttb_pkg::TMR_MAX)
                    tmr_next[ttb_pkg::T_INTERVAL] = tmr_reg[ttb_pkg::T_INTERVAL] + 16'd1;

                sec_pre_next = sec_tick ? '0 : sec_pre_reg + 1'b1;
                if (sec_tick)
                begin
                    if (tel_sum >= cfg.telemetry_interval_seconds)
                    begin
                        tel_cnt_next = '0;
                        flags_next[ttb_pkg::FLAG_TEL] = 1'b1;
                    end
                    else
                        tel_cnt_next = tel_sum;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (enables_reg[k] &&
                            tmr_reg[ttb_pkg::T_LOAD_ON + k] != ttb_pkg::TMR_MAX)
                            tmr_next[ttb_pkg::T_LOAD_ON + k] =
                                tmr_reg[ttb_pkg::T_LOAD_ON + k] + 16'd1;
                        if (tmr_reg[ttb_pkg::T_EVENING + k] != ttb_pkg::TMR_MAX &&
                            tmr_reg[ttb_pkg::T_EVENING + k] != '0)
                            tmr_next[ttb_pkg::T_EVENING + k] =
                                tmr_reg[ttb_pkg::T_EVENING + k] - 16'd1;
                    end
                end

                min_pre_next = min_tick ? '0 : min_pre_reg + 1'b1;
                if (min_tick && tmr_reg[ttb_pkg::T_UPTIME] != ttb_pkg::TMR_MAX)
                    tmr_next[ttb_pkg::T_UPTIME] = tmr_reg[ttb_pkg::T_UPTIME] + 16'd1;

                flags_next[ttb_pkg::FLAG_RST] = 1'b0;
                if (adc_sum == cfg.adc_sample_period_ticks)
                begin
                    adc_cnt_next = '0;
                    flags_next[ttb_pkg::FLAG_ADC] = 1'b1;
                end
                else
                    adc_cnt_next = adc_sum;

                // LED levels follow the timer value before the decrement.
                leds_next[0] = (tmr_reg[ttb_pkg::T_GREEN] != '0);
                if (leds_next[0])
                    tmr_next[ttb_pkg::T_GREEN] = tmr_reg[ttb_pkg::T_GREEN] - 16'd1;
                leds_next[1] = (tmr_reg[ttb_pkg::T_RED] != '0);
                if (leds_next[1])
                    tmr_next[ttb_pkg::T_RED] = tmr_reg[ttb_pkg::T_RED] - 16'd1;

                if (tmr_reg[ttb_pkg::T_WAKE] < ttb_pkg::WAKE_LIMIT)
                    tmr_next[ttb_pkg::T_WAKE] = tmr_reg[ttb_pkg::T_WAKE] + 16'd1;

                sleep_req = (tmr_reg[ttb_pkg::T_SHUTDOWN] == '0);
                if (!sleep_req)
                    tmr_next[ttb_pkg::T_SHUTDOWN] = tmr_reg[ttb_pkg::T_SHUTDOWN] - 16'd1;
            end
            ttb_pkg::CMD_WRITE:
            begin
                if (idx_ok)
                    tmr_next[timer_index] = write_value;
            end
            ttb_pkg::CMD_READ:
            begin
                if (idx_ok)
                    res.read_value = tmr_reg[timer_index];
            end
            ttb_pkg::CMD_ENABLE:
            begin
                enables_next = write_value[2:0];
            end
            ttb_pkg::CMD_CLEAR:
            begin
                if (write_value[0])
                    flags_next[ttb_pkg::FLAG_TEL] = 1'b0;
                if (write_value[1])
                    flags_next[ttb_pkg::FLAG_ADC] = 1'b0;
                if (write_value[2])
                    flags_next[ttb_pkg::FLAG_RST] = 1'b1;
            end
            default:
            begin
                sleep_req = 1'b0;
            end
        endcase

        res.telemetry_due       = flags_next[ttb_pkg::FLAG_TEL];
        res.adc_due             = flags_next[ttb_pkg::FLAG_ADC];
        res.green_led_on        = leds_next[0];
        res.red_led_on          = leds_next[1];
        res.radio_sleep_request = sleep_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ttb_pkg::NUM_TIMERS; k++)
                tmr_reg[k] <= '0;
            sec_pre_reg <= '0;
            min_pre_reg <= '0;
            tel_cnt_reg <= '0;
            adc_cnt_reg <= '0;
            enables_reg <= '0;
            flags_reg   <= '0;
            leds_reg    <= '0;
        end
        else if (fire)
        begin
            tmr_reg     <= tmr_next;
            sec_pre_reg <= sec_pre_next;
            min_pre_reg <= min_pre_next;
            tel_cnt_reg <= tel_cnt_next;
            adc_cnt_reg <= adc_cnt_next;
            enables_reg <= enables_next;
            flags_reg   <= flags_next;
            leds_reg    <= leds_next;
        end
    end

endmodule

// ===== design/tick_timer_bank.sv =====
// ----------------------------------------------------------------------------
// tick_timer_bank: twelve 16-bit timers driven by a 10 ms tick command
// Top level with the input word register, the timer core, the output word
// register and the configuration port.
// ----------------------------------------------------------------------------
// Each input word is one command: a tick (command 0) advances every counter,
// prescaler, LED timer and countdown at once; the other commands write or
// read one timer, set the three load timer enables, or clear flags. Every
// command produces exactly one output word carrying the read value (zero
// unless a read), the telemetry-due and ADC-due flags, both LED levels and
// the radio sleep request. The block takes one word per clock cycle while
// the output side keeps m_tready high: a word is captured in the input
// register when it is accepted, and the core then updates its state and
// loads the result into the output register once that register is free
// or is being emptied. The only stall comes from the output side holding
// m_tready low.
// Configuration registers (telemetry interval at address 0, ADC sample
// period at address 4) are to be written only while no command is in flight.
// ----------------------------------------------------------------------------
module tick_timer_bank (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] timer_index, [19:4] write_value, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] read_value, [16] telemetry_due,
                                   // [17] adc_due, [18] green_led_on,
                                   // [19] red_led_on, [20] radio_sleep_request
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ttb_pkg::cfg_t cfg;
    ttb_pkg::res_t core_res;

    logic          in_vld_reg;
    logic [2:0]    in_cmd_reg;
    logic [3:0]    in_idx_reg;
    logic [15:0]   in_wval_reg;
    logic          out_vld_reg;
    ttb_pkg::res_t out_res_reg;
    logic          core_fire;

    // The core runs the held command whenever the output register is free
    // or is being emptied in this same cycle.
    assign core_fire = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || core_fire;

    ttb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (core_fire),
        .command     (in_cmd_reg),
        .timer_index (in_idx_reg),
        .write_value (in_wval_reg),
        .cfg         (cfg),
        .res         (core_res)
    );

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_idx_reg  <= s_tdata[3:0];
            in_wval_reg <= s_tdata[19:4];
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (core_fire)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_fire)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_res_reg};

endmodule

// ===== tb/sv/tb_tick_timer_bank.sv =====
// ----------------------------------------------------------------------------
// tb_tick_timer_bank: self-checking testbench of the tick timer bank
// Streams command words into the bank with bursty timing, stalls the result
// side on its own pattern and checks every result word against a cycle-free
// predictor of the timers, prescalers, flags and LED levels.
// ----------------------------------------------------------------------------
module tb_tick_timer_bank;

    // Command codes the block does not decode; they must change nothing.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_TEL_INTERVAL = {ttb_pkg::REG_TEL_INTERVAL, 2'b00};
    localparam logic [2:0] ADDR_ADC_PERIOD   = {ttb_pkg::REG_ADC_PERIOD, 2'b00};

    // Settings walked through by the random phases, extremes included.
    localparam int NUM_PHASES = 7;
    localparam int WORDS_PER_PHASE = 270;
    localparam logic [15:0] TEL_SETTINGS [NUM_PHASES] =
        '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd0, 16'd1};
    localparam logic [15:0] ADC_SETTINGS [NUM_PHASES] =
        '{16'd1, 16'd0, 16'hFFFF, 16'd37, 16'd150, 16'd7, 16'd2};

    // No word moving on either stream for this many cycles means a hang.
    // The slowest correct run waits at most a sender gap plus a receiver
    // stall per word, so this limit is far beyond it.
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  index;
        logic [15:0] value;
    } cmd_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tick_timer_bank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted state of the bank. It is advanced once per accepted command
    // word, in acceptance order, which is also the order of the results.
    // ------------------------------------------------------------------------
    ttb_pkg::cfg_t bank_cfg = '0;
    logic [15:0]   timers [ttb_pkg::NUM_TIMERS];
    int            second_ticks = 0;
    int            minute_ticks = 0;
    logic [15:0]   tel_seconds = '0;
    logic [15:0]   adc_ticks = '0;
    logic [2:0]    load_enables = '0;
    logic          tel_due = 1'b0;
    logic          adc_due = 1'b0;
    logic          adc_restart = 1'b0;
    logic          green_level = 1'b0;
    logic          red_level = 1'b0;

    initial
    begin
        foreach (timers[k])
            timers[k] = '0;
    end

    cmd_word_t     pending_words [$];
    ttb_pkg::res_t expected_words [$];
    int            words_queued = 0;
    int            words_accepted = 0;
    int            error_count = 0;
    int            quiet_cycles = 0;
    logic          word_taken = 1'b0;
    int            gap_left = 0;
    int            burst_left = 0;
    int            rx_run_left = 0;

    // Saturating increment of one timer.
    function automatic void bump(input int slot);
        if (timers[slot] != ttb_pkg::TMR_MAX)
            timers[slot] = timers[slot] + 16'd1;
    endfunction

    // Applies one command word to the predicted state and returns the result
    // word that the bank has to produce for it.
    function automatic ttb_pkg::res_t bank_response(input logic [2:0] cmd,
                                                    input logic [3:0] idx,
                                                    input logic [15:0] wv);
        ttb_pkg::res_t r;
        r = '0;
        case (cmd)
            ttb_pkg::CMD_TICK:
            begin
                bump(ttb_pkg::T_INTERVAL);

                second_ticks++;
                if (second_ticks >= ttb_pkg::TICKS_PER_SECOND)
                begin
                    second_ticks = 0;
                    // The seconds count is added in 16 bits before the compare, and a
                    // zero interval raises the flag every second.
                    tel_seconds = tel_seconds + 16'd1;
                    if (tel_seconds >= bank_cfg.telemetry_interval_seconds)
                    begin
                        tel_seconds = '0;
                        tel_due = 1'b1;
                    end
                    for (int k = 0; k < 3; k++)
                        if (load_enables[k])
                            bump(ttb_pkg::T_LOAD_ON + k);
                    // Countdowns rest at zero, and the all-ones value is held.
                    for (int k = 0; k < 3; k++)
                        if (timers[ttb_pkg::T_EVENING + k] != ttb_pkg::TMR_MAX &&
                            timers[ttb_pkg::T_EVENING + k] != 0)
                            timers[ttb_pkg::T_EVENING + k] =
                                timers[ttb_pkg::T_EVENING + k] - 16'd1;
                end

                minute_ticks++;
                if (minute_ticks >= ttb_pkg::TICKS_PER_MINUTE)
                begin
                    minute_ticks = 0;
                    bump(ttb_pkg::T_UPTIME);
                end

                // A restart request from a clear command takes effect here.
                if (adc_restart)
                begin
                    adc_restart = 1'b0;
                    adc_ticks = '0;
                end
                adc_ticks = adc_ticks + 16'd1;
                if (adc_ticks == bank_cfg.adc_sample_period_ticks)
                begin
                    adc_ticks = '0;
                    adc_due = 1'b1;
                end

                // LED level follows the timer value before its decrement.
                green_level = (timers[ttb_pkg::T_GREEN] != 0);
                if (green_level)
                    timers[ttb_pkg::T_GREEN] = timers[ttb_pkg::T_GREEN] - 16'd1;
                red_level = (timers[ttb_pkg::T_RED] != 0);
                if (red_level)
                    timers[ttb_pkg::T_RED] = timers[ttb_pkg::T_RED] - 16'd1;

                if (timers[ttb_pkg::T_WAKE] < ttb_pkg::WAKE_LIMIT)
                    timers[ttb_pkg::T_WAKE] = timers[ttb_pkg::T_WAKE] + 16'd1;

                r.radio_sleep_request = (timers[ttb_pkg::T_SHUTDOWN] == 0);
                if (timers[ttb_pkg::T_SHUTDOWN] != 0)
                    timers[ttb_pkg::T_SHUTDOWN] = timers[ttb_pkg::T_SHUTDOWN] - 16'd1;
            end
            ttb_pkg::CMD_WRITE:
                if (idx < ttb_pkg::T_COUNT)
                    timers[idx] = wv;
            ttb_pkg::CMD_READ:
                if (idx < ttb_pkg::T_COUNT)
                    r.read_value = timers[idx];
            ttb_pkg::CMD_ENABLE:
                load_enables = wv[2:0];
            ttb_pkg::CMD_CLEAR:
            begin
                if (wv[ttb_pkg::FLAG_TEL])
                    tel_due = 1'b0;
                if (wv[ttb_pkg::FLAG_ADC])
                    adc_due = 1'b0;
                if (wv[ttb_pkg::FLAG_RST])
                    adc_restart = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.telemetry_due = tel_due;
        r.adc_due = adc_due;
        r.green_led_on = green_level;
        r.red_led_on = red_level;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_word(input logic [2:0] cmd, input logic [3:0] idx,
                              input logic [15:0] wv);
        cmd_word_t w;
        w.cmd = cmd;
        w.index = idx;
        w.value = wv;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [2:0] addr, input logic [15:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(data);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] tel, input logic [15:0] adc);
        apb_write(ADDR_TEL_INTERVAL, tel);
        apb_write(ADDR_ADC_PERIOD, adc);
        bank_cfg.telemetry_interval_seconds = tel;
        bank_cfg.adc_sample_period_ticks = adc;
    endtask

    // Returns once every queued word has been taken and every result seen.
    task automatic drain();
        while (words_accepted != words_queued || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sender: words go out at the falling edge in bursts of random length,
    // separated by random gaps. A word stays on the bus until the rising edge
    // that accepts it; the next one replaces it at the following falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : word_driver
        cmd_word_t w;
        if (!s_tvalid || word_taken)
        begin
            if (gap_left != 0 || pending_words.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= w.cmd;
                s_tdata <= {4'b0000, w.value, w.index};
                if (burst_left <= 1)
                begin
                    // Mostly short bursts, now and then a long unbroken run.
                    burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready runs of random length broken by stalls of random
    // length; some runs are long so that stretches without stalls occur.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : ready_pattern
        int n;
        if (rx_run_left != 0)
            rx_run_left <= rx_run_left - 1;
        else if (m_tready)
        begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (n == 0)
                rx_run_left <= $urandom_range(0, 30);
            else
            begin
                m_tready <= 1'b0;
                rx_run_left <= n - 1;
            end
        end
        else
        begin
            m_tready <= 1'b1;
            rx_run_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 30);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge an accepted result word is checked against
    // the oldest prediction, and an accepted command word is run through the
    // predictor. Checking comes first, so a result never meets its own word.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        ttb_pkg::res_t got;
        ttb_pkg::res_t want;
        word_taken <= s_tvalid && s_tready;
        if (m_tvalid && m_tready)
        begin
            got = ttb_pkg::res_t'(m_tdata[20:0]);
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word %h arrived with none expected", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("read_value", want.read_value, got.read_value);
                check_field("telemetry_due", want.telemetry_due, got.telemetry_due);
                check_field("adc_due", want.adc_due, got.adc_due);
                check_field("green_led_on", want.green_led_on, got.green_led_on);
                check_field("red_led_on", want.red_led_on, got.red_led_on);
                check_field("radio_sleep_request", want.radio_sleep_request,
                            got.radio_sleep_request);
                check_field("tdata padding", 0, m_tdata[23:21]);
            end
        end
        if (s_tvalid && s_tready)
        begin
            expected_words.push_back(bank_response(s_tuser, s_tdata[3:0], s_tdata[19:4]));
            words_accepted++;
        end
    end

    // Watchdog on stream progress; also covers a bank that never answers.
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("** tick_timer_bank: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [2:0]  cmd;
        logic [3:0]  idx;
        logic [15:0] val;
        int          r;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset configuration (both registers zero).
        queue_word(ttb_pkg::CMD_READ, ttb_pkg::T_INTERVAL, 16'h0000);   // reset value
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // shutdown at zero: sleep
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_INTERVAL, 16'hFFFE);
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // interval saturates
        queue_word(ttb_pkg::CMD_READ, ttb_pkg::T_INTERVAL, 16'h0000);
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_WAKE, 16'd300);  // above the wake limit
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);
        queue_word(ttb_pkg::CMD_READ, ttb_pkg::T_WAKE, 16'h0000);  // still 300
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_GREEN, 16'd1);
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_RED, 16'd2);
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // both LEDs lit
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // green dark, red lit
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // both dark
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_SHUTDOWN, 16'd1);
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // no sleep request
        queue_word(ttb_pkg::CMD_TICK, 4'd0, 16'h0000);          // sleep request
        queue_word(ttb_pkg::CMD_WRITE, 4'hF, 16'hFFFF);         // out-of-range write ignored
        queue_word(ttb_pkg::CMD_READ, 4'hF, 16'hFFFF);          // out-of-range read gives zero
        queue_word(ttb_pkg::CMD_READ, ttb_pkg::T_COUNT, 16'h0000);
        queue_word(CMD_SPARE_FIRST, ttb_pkg::T_LOAD_ON, 16'hFFFF);  // undecoded commands
        queue_word(CMD_SPARE_LAST, 4'hF, 16'hFFFF);
        queue_word(ttb_pkg::CMD_ENABLE, 4'd0, 16'hFFFF);
        queue_word(ttb_pkg::CMD_CLEAR, 4'd0, 16'hFFFF);
        queue_word(ttb_pkg::CMD_WRITE, ttb_pkg::T_EVENING, 16'hFFFF);  // held countdown
        drain();

        // Random phases, one register setting each. Ticks dominate so that
        // seconds, ADC periods and the LED and countdown timers all roll.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_config(TEL_SETTINGS[p], ADC_SETTINGS[p]);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                idx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 11));
                // Small values make the LED and shutdown timers
                // expire within a phase; the extremes hit saturation.
                case ($urandom_range(0, 4))
                    0, 1: val = 16'($urandom_range(0, 300));
                    2:
                        case ($urandom_range(0, 5))
                            0: val = 16'h0000;
                            1: val = 16'h0001;
                            2: val = 16'hFFFE;
                            3: val = 16'hFFFF;
                            4: val = ttb_pkg::WAKE_LIMIT - 16'd1;
                            default: val = ttb_pkg::WAKE_LIMIT;
                        endcase
                    default: val = 16'($urandom);
                endcase
                if (r < 60)
                    cmd = ttb_pkg::CMD_TICK;
                else if (r < 72)
                    cmd = ttb_pkg::CMD_WRITE;
                else if (r < 84)
                    cmd = ttb_pkg::CMD_READ;
                else if (r < 89)
                    cmd = ttb_pkg::CMD_ENABLE;
                else if (r < 96)
                    cmd = ttb_pkg::CMD_CLEAR;
                else
                    cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                queue_word(cmd, idx, val);
            end
            drain();
        end

        // The last result has left; give the pipeline its latency and stop.
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("** tick_timer_bank: PASSED **");
        else
            $display("** tick_timer_bank: FAILED **");
        $finish;
    end

endmodule
